### hdl/rrcs_pkg.sv
// ----------------------------------------------------------------------------
// rrcs_pkg
// Shared widths, action and status codes, and the per-cell control word for
// the random replacement cache set.
// ----------------------------------------------------------------------------
package rrcs_pkg;

	localparam int SET_WAYS  = 8;
	localparam int TAG_W     = 20;
	localparam int ACTION_W  = 3;
	localparam int STATUS_W  = 2;
	localparam int LFSR_W    = 16;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int WAY_IDX_W = (SET_WAYS > 1) ? $clog2(SET_WAYS) : 1;
	localparam int WAY_CNT_W = $clog2(SET_WAYS + 1);

	localparam logic [LFSR_W-1:0] LFSR_TOGGLE = 16'hB400;
	localparam logic [LFSR_W-1:0] SEED_RESET  = 16'h0001;

	// register index, taken from the word address bit
	localparam logic REG_RANDOM_SEED = 1'b0;

	typedef logic [TAG_W-1:0]    tag_t;
	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LFSR_W-1:0]   lfsr_t;

	localparam action_t ACT_LOOKUP    = 3'd0;
	localparam action_t ACT_INSERT    = 3'd1;
	localparam action_t ACT_EVICT     = 3'd2;
	localparam action_t ACT_SET_DIRTY = 3'd3;
	localparam action_t ACT_CLR_DIRTY = 3'd4;
	localparam action_t ACT_CLEAR     = 3'd5;

	localparam status_t ST_DONE        = 2'd0;
	localparam status_t ST_PRESENT     = 2'd1;
	localparam status_t ST_NOT_FULL    = 2'd2;
	localparam status_t ST_FULL        = 2'd3;

	// control word for one way cell
	typedef struct packed {
		logic shift;    // take the upper neighbor's entry
		logic load;     // write the incoming tag as a clean entry
		logic mark;     // write the dirty mark
		logic mark_val; // value of the dirty mark
	} cell_ctl_t;

endpackage

### hdl/rrcs_if.sv
// ----------------------------------------------------------------------------
// rrcs_req_if / rrcs_rsp_if
// Valid/ready channels carrying request words and result words.
// ----------------------------------------------------------------------------
interface rrcs_req_if;
	logic             valid;
	logic             ready;
	rrcs_pkg::action_t action;
	rrcs_pkg::tag_t    tag;

	modport source (output valid, output action, output tag, input ready);
	modport sink   (input valid, input action, input tag, output ready);
endinterface

interface rrcs_rsp_if;
	logic              valid;
	logic              ready;
	logic              hit;
	rrcs_pkg::status_t status;
	logic              victim_valid;
	rrcs_pkg::tag_t    victim_tag;
	logic              victim_dirty;

	modport source (output valid, output hit, output status, output victim_valid,
		output victim_tag, output victim_dirty, input ready);
	modport sink   (input valid, input hit, input status, input victim_valid,
		input victim_tag, input victim_dirty, output ready);
endinterface

### hdl/rrcs_cell.sv
// ----------------------------------------------------------------------------
// rrcs_cell
// One way of the set: holds a tag and dirty mark, compares against the
// request tag, and can take its upper neighbor's entry on an eviction.
// ----------------------------------------------------------------------------
module rrcs_cell (
	input  logic                clk,
	input  rrcs_pkg::cell_ctl_t ctl,
	input  rrcs_pkg::tag_t      key,
	input  rrcs_pkg::tag_t      nbr_tag,
	input  logic                nbr_dirty,
	output rrcs_pkg::tag_t      tag,
	output logic                dirty,
	output logic                match
);

	rrcs_pkg::tag_t tag_q;
	logic           dirty_q;

	// shift down, load a new entry, or update the mark
	always_ff @(posedge clk) begin
		priority if (ctl.shift) begin
			tag_q   <= nbr_tag;
			dirty_q <= nbr_dirty;
		end else if (ctl.load) begin
			tag_q   <= key;
			dirty_q <= 1'b0;
		end else if (ctl.mark) begin
			dirty_q <= ctl.mark_val;
		end
	end

	assign tag   = tag_q;
	assign dirty = dirty_q;
	assign match = (tag_q == key);

endmodule

### hdl/rrcs_lfsr.sv
// ----------------------------------------------------------------------------
// rrcs_lfsr
// 16-bit Galois LFSR (x^16+x^14+x^13+x^11+1) choosing the eviction victim.
// ----------------------------------------------------------------------------
module rrcs_lfsr (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  rrcs_pkg::lfsr_t seed,
	input  logic            step,
	output rrcs_pkg::lfsr_t state
);

	rrcs_pkg::lfsr_t lfsr_q;
	rrcs_pkg::lfsr_t stepped;

	// shift right, toggle taps when the low bit falls out
	always_comb begin
		stepped = lfsr_q >> 1;
		if (lfsr_q[0]) begin
			stepped = stepped ^ rrcs_pkg::LFSR_TOGGLE;
		end
	end

	// a zero seed would lock up: load one instead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= rrcs_pkg::SEED_RESET;
		end else if (load) begin
			lfsr_q <= (seed == '0) ? rrcs_pkg::lfsr_t'(1) : seed;
		end else if (step) begin
			lfsr_q <= stepped;
		end
	end

	assign state = lfsr_q;

endmodule

### hdl/random_replacement_cache_set.sv
// The result word is registered and appears in the cycle after acceptance.
// Throughput: one word per cycle unless rsp stalls; the way cells compare
// in parallel and update at the same edge, so the next word sees the new set.
// Reset: occupancy clears to empty, the seed register and the LFSR load 1.
// Tag and dirty storage is not reset; ways above the occupancy are unused.
// ----------------------------------------------------------------------------
// random_replacement_cache_set
// Associative cache set with insertion-ordered ways, dirty marks and
// LFSR-driven random eviction, built as a chain of way cells.
// ----------------------------------------------------------------------------
module random_replacement_cache_set (
	input  logic                              clk,
	input  logic                              arst_n,
	rrcs_req_if.sink                          req,
	rrcs_rsp_if.source                        rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rrcs_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [rrcs_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [rrcs_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);

	localparam int W = rrcs_pkg::SET_WAYS;

	rrcs_pkg::lfsr_t seed_q;
	rrcs_pkg::lfsr_t lfsr;
	logic            seed_wr;

	logic [rrcs_pkg::WAY_CNT_W-1:0] occ_q;
	logic [rrcs_pkg::WAY_CNT_W-1:0] occ_d;

	rrcs_pkg::tag_t      cell_tag   [W];
	logic                cell_dirty [W];
	logic [W-1:0]        cell_match;
	rrcs_pkg::cell_ctl_t cell_ctl   [W];

	logic [W-1:0]                   hit_vec;
	logic [W-1:0]                   first_hit;
	logic                           found;
	logic                           any_hit;
	logic                           full;
	logic [rrcs_pkg::WAY_IDX_W-1:0] vidx;
	logic                           accept;
	logic                           lfsr_step;

	logic              hit_d;
	rrcs_pkg::status_t status_d;
	logic              vvalid_d;
	rrcs_pkg::tag_t    vtag_d;
	logic              vdirty_d;

	logic              out_valid_q;
	logic              hit_q;
	rrcs_pkg::status_t status_q;
	logic              vvalid_q;
	rrcs_pkg::tag_t    vtag_q;
	logic              vdirty_q;

	// configuration port
	assign pready  = 1'b1;
	assign seed_wr = psel & penable & pwrite & (paddr[2] == rrcs_pkg::REG_RANDOM_SEED);
	assign prdata  = (paddr[2] == rrcs_pkg::REG_RANDOM_SEED)
		? rrcs_pkg::CFG_DATA_W'(seed_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= rrcs_pkg::SEED_RESET;
		end else if (seed_wr) begin
			seed_q <= pwdata[rrcs_pkg::LFSR_W-1:0];
		end
	end

	rrcs_lfsr u_lfsr (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (seed_wr),
		.seed   (pwdata[rrcs_pkg::LFSR_W-1:0]),
		.step   (lfsr_step),
		.state  (lfsr)
	);

	// chain of way cells; the top way has no upper neighbor
	for (genvar g = 0; g < W; g++) begin : g_way
		rrcs_pkg::tag_t nbr_tag;
		logic           nbr_dirty;
		if (g < W - 1) begin : g_mid
			assign nbr_tag   = cell_tag[g+1];
			assign nbr_dirty = cell_dirty[g+1];
		end else begin : g_top
			assign nbr_tag   = cell_tag[g];
			assign nbr_dirty = cell_dirty[g];
		end
		rrcs_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[g]),
			.key       (req.tag),
			.nbr_tag   (nbr_tag),
			.nbr_dirty (nbr_dirty),
			.tag       (cell_tag[g]),
			.dirty     (cell_dirty[g]),
			.match     (cell_match[g])
		);
	end

	// qualify matches with occupancy and keep the lowest one
	always_comb begin
		found = 1'b0;
		for (int i = 0; i < W; i++) begin
			hit_vec[i]   = cell_match[i] & (rrcs_pkg::WAY_CNT_W'(i) < occ_q);
			first_hit[i] = hit_vec[i] & ~found;
			found        = found | hit_vec[i];
		end
	end

	assign any_hit = |hit_vec;
	assign full    = (occ_q == rrcs_pkg::WAY_CNT_W'(W));
	assign vidx    = rrcs_pkg::WAY_IDX_W'(lfsr % W);
	assign accept  = req.valid & req.ready;
	assign req.ready = ~out_valid_q | rsp.ready;

	// decode the action into cell controls and a result word
	always_comb begin
		occ_d     = occ_q;
		lfsr_step = 1'b0;
		hit_d     = 1'b0;
		status_d  = rrcs_pkg::ST_DONE;
		vvalid_d  = 1'b0;
		vtag_d    = '0;
		vdirty_d  = 1'b0;
		for (int i = 0; i < W; i++) begin
			cell_ctl[i] = '0;
		end
		unique case (req.action)
			rrcs_pkg::ACT_LOOKUP: begin
				hit_d = any_hit;
			end
			rrcs_pkg::ACT_INSERT: begin
				hit_d = any_hit;
				priority if (any_hit) begin
					status_d = rrcs_pkg::ST_PRESENT;
				end else if (full) begin
					status_d = rrcs_pkg::ST_FULL;
				end else begin
					occ_d = occ_q + 1'b1;
					for (int i = 0; i < W; i++) begin
						cell_ctl[i].load = accept & (rrcs_pkg::WAY_CNT_W'(i) == occ_q);
					end
				end
			end
			rrcs_pkg::ACT_EVICT: begin
				if (full) begin
					vvalid_d  = 1'b1;
					vtag_d    = cell_tag[vidx];
					vdirty_d  = cell_dirty[vidx];
					occ_d     = rrcs_pkg::WAY_CNT_W'(W - 1);
					lfsr_step = accept;
					for (int i = 0; i < W - 1; i++) begin
						cell_ctl[i].shift = accept
							& (rrcs_pkg::WAY_IDX_W'(i) >= vidx);
					end
				end else begin
					status_d = rrcs_pkg::ST_NOT_FULL;
				end
			end
			rrcs_pkg::ACT_SET_DIRTY, rrcs_pkg::ACT_CLR_DIRTY: begin
				hit_d = any_hit;
				for (int i = 0; i < W; i++) begin
					cell_ctl[i].mark     = accept & first_hit[i];
					cell_ctl[i].mark_val = (req.action == rrcs_pkg::ACT_SET_DIRTY);
				end
			end
			rrcs_pkg::ACT_CLEAR: begin
				occ_d = '0;
			end
			default: begin
			end
		endcase
	end

	// hold occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept) begin
			occ_q <= occ_d;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q    <= hit_d;
			status_q <= status_d;
			vvalid_q <= vvalid_d;
			vtag_q   <= vtag_d;
			vdirty_q <= vdirty_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.hit          = hit_q;
	assign rsp.status       = status_q;
	assign rsp.victim_valid = vvalid_q;
	assign rsp.victim_tag   = vtag_q;
	assign rsp.victim_dirty = vdirty_q;

endmodule
